FILE: rtl/sfd_pkg.sv
// Shared types and constants for the SLIP frame decoder.
// No dependencies; used by every other file of the block.
`default_nettype none
package sfd_pkg;

  localparam int MAX_FRAME = 1024;
  localparam int CNT_W     = 11;
  localparam int OFF_W     = 10;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0]  END_CODE     = 8'hC0;
  localparam logic [7:0]  ESC_CODE     = 8'hDB;
  localparam logic [7:0]  ESC_END_CODE = 8'hDC;
  localparam logic [7:0]  ESC_ESC_CODE = 8'hDD;
  localparam logic [47:0] CLIENT_WORD  = {8'h43, 8'h4C, 8'h49, 8'h45, 8'h4E, 8'h54};

  localparam logic [15:0] GAP_THRESHOLD_RESET = 16'd100;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] tick;
    logic        is_end;
    logic        is_esc;
    logic        is_esc_end;
    logic        is_esc_esc;
  } sfd_item_t;

  typedef struct packed {
    logic             data_valid;
    logic [7:0]       data_byte;
    logic [OFF_W-1:0] data_offset;
    logic             byte_dropped;
    logic             frame_done;
    logic [CNT_W-1:0] frame_length;
    logic             send_client_reply;
  } sfd_result_t;

endpackage
`default_nettype wire

FILE: rtl/sfd_front.sv
// Front end: accepts raw items and tags SLIP control codes.
// Depends on sfd_pkg; feeds sfd_queue.
`default_nettype none
module sfd_front (
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [15:0]       tick,
  input  wire logic              q_full,
  output logic                   push,
  output sfd_pkg::sfd_item_t     push_item
);

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    push_item.rx_byte    = rx_byte;
    push_item.tick       = tick;
    push_item.is_end     = (rx_byte == sfd_pkg::END_CODE);
    push_item.is_esc     = (rx_byte == sfd_pkg::ESC_CODE);
    push_item.is_esc_end = (rx_byte == sfd_pkg::ESC_END_CODE);
    push_item.is_esc_esc = (rx_byte == sfd_pkg::ESC_ESC_CODE);
  end

endmodule
`default_nettype wire

FILE: rtl/sfd_queue.sv
// Short item queue between front and back ends.
// Depends on sfd_pkg for depth and entry type.
`default_nettype none
module sfd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sfd_pkg::sfd_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output sfd_pkg::sfd_item_t      head_item
);

  sfd_pkg::sfd_item_t                mem [sfd_pkg::QDEPTH];
  logic [sfd_pkg::QPTR_W-1:0]        wr_ptr;
  logic [sfd_pkg::QPTR_W-1:0]        rd_ptr;
  logic [sfd_pkg::QCNT_W-1:0]        count;

  assign full       = (count == sfd_pkg::QCNT_W'(sfd_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sfd_pkg::QPTR_W'(sfd_pkg::QDEPTH - 1)) ? '0
                                                                    : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sfd_pkg::QPTR_W'(sfd_pkg::QDEPTH - 1)) ? '0
                                                                    : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sfd_back.sv
// Back end: unescaping, frame counting, CLIENT detection, result register.
// Depends on sfd_pkg; drains sfd_queue.
`default_nettype none
module sfd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               head_valid,
  input  wire sfd_pkg::sfd_item_t head_item,
  output logic                    pop,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output sfd_pkg::sfd_result_t    res
);

  logic [15:0]               gap_threshold;
  logic                      escape_pending;
  logic [sfd_pkg::CNT_W-1:0] byte_count;
  logic [15:0]               last_frame_tick;
  logic [47:0]               recent_bytes;

  logic                      escape_pending_next;
  logic [sfd_pkg::CNT_W-1:0] byte_count_next;
  logic [15:0]               last_frame_tick_next;
  logic [47:0]               recent_bytes_next;
  sfd_pkg::sfd_result_t      res_next;

  logic [15:0] gap;
  logic        detect;
  logic [47:0] hist;
  logic [7:0]  dec;
  logic        store;

  assign cfg_ready = 1'b1;
  assign pop       = head_valid && (!res_valid || !res_stall);

  always_comb begin
    gap    = head_item.tick - last_frame_tick;
    detect = (gap > gap_threshold);
    hist   = {recent_bytes[39:0], head_item.rx_byte};

    escape_pending_next  = escape_pending;
    byte_count_next      = byte_count;
    last_frame_tick_next = last_frame_tick;
    recent_bytes_next    = detect ? hist : recent_bytes;
    res_next             = '0;
    res_next.send_client_reply = detect && (hist == sfd_pkg::CLIENT_WORD);

    dec   = head_item.rx_byte;
    store = 1'b0;
    if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (head_item.is_esc_end) begin
        dec = sfd_pkg::END_CODE;
      end else if (head_item.is_esc_esc) begin
        dec = sfd_pkg::ESC_CODE;
      end
      store = 1'b1;
    end else if (head_item.is_end) begin
      last_frame_tick_next = head_item.tick;
      if (byte_count != '0) begin
        res_next.frame_done   = 1'b1;
        res_next.frame_length = byte_count;
      end
      byte_count_next = '0;
    end else if (head_item.is_esc) begin
      escape_pending_next = 1'b1;
    end else begin
      store = 1'b1;
    end

    if (store) begin
      if (byte_count < sfd_pkg::CNT_W'(sfd_pkg::MAX_FRAME)) begin
        res_next.data_valid  = 1'b1;
        res_next.data_byte   = dec;
        res_next.data_offset = byte_count[sfd_pkg::OFF_W-1:0];
        byte_count_next      = byte_count + 1'b1;
      end else begin
        res_next.byte_dropped = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold   <= sfd_pkg::GAP_THRESHOLD_RESET;
      escape_pending  <= 1'b0;
      byte_count      <= '0;
      last_frame_tick <= '0;
      recent_bytes    <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_threshold <= cfg_data;
      end
      if (pop) begin
        escape_pending  <= escape_pending_next;
        byte_count      <= byte_count_next;
        last_frame_tick <= last_frame_tick_next;
        recent_bytes    <= recent_bytes_next;
        res_valid       <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/slip_frame_decoder_unit.sv
// Top level of the SLIP frame decoder: front end, item queue, back end.
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back.
//
// Receive-side SLIP deframer. Each accepted item (rx_byte, tick) yields
// exactly one result: an unescaped data byte with its frame offset, a drop
// flag once a frame holds MAX_FRAME bytes, a frame-done report with the
// length on an unescaped END ending a non-empty frame, and a CLIENT reply
// request on the word CLIENT while the tick gap since the last END exceeds
// the threshold register. Throughput is one item per clock unless
// result_stall holds results; the escape flag, byte count and history are
// registered with each result. Items pass the two-entry queue, then the
// result register. No clearing pass follows reset. The threshold register
// resets to 100 and is written through cfg_valid/cfg_data, always ready.
`default_nettype none
module slip_frame_decoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [15:0]                 cfg_data,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic [7:0]                  rx_byte,
  input  wire logic [15:0]                 tick,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic                             data_valid,
  output logic [7:0]                       data_byte,
  output logic [sfd_pkg::OFF_W-1:0]        data_offset,
  output logic                             byte_dropped,
  output logic                             frame_done,
  output logic [sfd_pkg::CNT_W-1:0]        frame_length,
  output logic                             send_client_reply
);

  logic                 push;
  logic                 q_full;
  logic                 pop;
  logic                 head_valid;
  sfd_pkg::sfd_item_t   push_item;
  sfd_pkg::sfd_item_t   head_item;
  sfd_pkg::sfd_result_t res;

  sfd_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .rx_byte    (rx_byte),
    .tick       (tick),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  sfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (result_valid),
    .res_stall  (result_stall),
    .res        (res)
  );

  assign data_valid        = res.data_valid;
  assign data_byte         = res.data_byte;
  assign data_offset       = res.data_offset;
  assign byte_dropped      = res.byte_dropped;
  assign frame_done        = res.frame_done;
  assign frame_length      = res.frame_length;
  assign send_client_reply = res.send_client_reply;

endmodule
`default_nettype wire

FILE: rtl/sfd_checker.sv
// Port-level checks for slip_frame_decoder_unit, bound to the top level.
// Depends on sfd_pkg.
`default_nettype none
module sfd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      result_valid,
  input wire logic                      result_stall,
  input wire logic                      data_valid,
  input wire logic [7:0]                data_byte,
  input wire logic [sfd_pkg::OFF_W-1:0] data_offset,
  input wire logic                      byte_dropped,
  input wire logic                      frame_done,
  input wire logic [sfd_pkg::CNT_W-1:0] frame_length,
  input wire logic                      send_client_reply
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(data_byte)
      && $stable(data_offset) && $stable(frame_length) && $stable(data_valid))
    else $error("stalled result changed");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(data_valid && byte_dropped) && !(frame_done && data_valid)
      && !(frame_done && byte_dropped))
    else $error("conflicting result flags");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !data_valid |-> data_byte == 8'h00 && data_offset == '0)
    else $error("data fields nonzero without data_valid");

  a_length: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (frame_done ? (frame_length != '0
      && frame_length <= sfd_pkg::CNT_W'(sfd_pkg::MAX_FRAME)) : frame_length == '0))
    else $error("frame length out of range");

endmodule

bind slip_frame_decoder_unit sfd_checker u_chk (.*);
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for slip_frame_decoder_unit (SLIP receive deframer).
// Predicts unescaped bytes, frame ends and CLIENT detection per item; needs sfd_pkg.
module testbench;

  localparam int LIMIT = 400000;

  class slip_scoreboard;
    logic [15:0]               gap_threshold;
    logic                      esc_seen;
    logic [sfd_pkg::CNT_W-1:0] fill;
    logic [15:0]               last_end_tick;
    logic [47:0]               history;
    sfd_pkg::sfd_result_t      decoded_q[$];
    int                        errors;

    function new();
      gap_threshold = sfd_pkg::GAP_THRESHOLD_RESET;
      esc_seen      = 1'b0;
      fill          = '0;
      last_end_tick = '0;
      history       = '0;
      errors        = 0;
    endfunction

    function void set_gap_threshold(logic [15:0] v);
      gap_threshold = v;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    // one accepted item -> one predicted result
    function void decode_byte(logic [7:0] raw, logic [15:0] t);
      sfd_pkg::sfd_result_t r;
      logic [7:0]  c;
      logic [15:0] gap;
      logic        store;
      r     = '0;
      c     = raw;
      store = 1'b0;
      gap   = t - last_end_tick;
      if (gap > gap_threshold) begin
        history = {history[39:0], raw};
        r.send_client_reply = (history == sfd_pkg::CLIENT_WORD);
      end
      if (esc_seen) begin
        esc_seen = 1'b0;
        if (c == sfd_pkg::ESC_END_CODE) c = sfd_pkg::END_CODE;
        else if (c == sfd_pkg::ESC_ESC_CODE) c = sfd_pkg::ESC_CODE;
        store = 1'b1;
      end else if (c == sfd_pkg::END_CODE) begin
        last_end_tick = t;
        if (fill != 0) begin
          r.frame_done   = 1'b1;
          r.frame_length = fill;
        end
        fill = '0;
      end else if (c == sfd_pkg::ESC_CODE) begin
        esc_seen = 1'b1;
      end else begin
        store = 1'b1;
      end
      if (store) begin
        if (fill < sfd_pkg::MAX_FRAME) begin
          r.data_valid  = 1'b1;
          r.data_byte   = c;
          r.data_offset = fill[sfd_pkg::OFF_W-1:0];
          fill          = fill + 1'b1;
        end else begin
          r.byte_dropped = 1'b1;
        end
      end
      decoded_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(sfd_pkg::sfd_result_t got);
      sfd_pkg::sfd_result_t exp;
      if (decoded_q.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      exp = decoded_q.pop_front();
      if (got.data_valid !== exp.data_valid)
        report($sformatf("data_valid %0d exp %0d", got.data_valid, exp.data_valid));
      if (got.data_byte !== exp.data_byte)
        report($sformatf("data_byte %h exp %h", got.data_byte, exp.data_byte));
      if (got.data_offset !== exp.data_offset)
        report($sformatf("data_offset %0d exp %0d", got.data_offset, exp.data_offset));
      if (got.byte_dropped !== exp.byte_dropped)
        report($sformatf("byte_dropped %0d exp %0d", got.byte_dropped, exp.byte_dropped));
      if (got.frame_done !== exp.frame_done)
        report($sformatf("frame_done %0d exp %0d", got.frame_done, exp.frame_done));
      if (got.frame_length !== exp.frame_length)
        report($sformatf("frame_length %0d exp %0d", got.frame_length, exp.frame_length));
      if (got.send_client_reply !== exp.send_client_reply)
        report($sformatf("send_client_reply %0d exp %0d",
                         got.send_client_reply, exp.send_client_reply));
    endtask
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [15:0]               cfg_data;
  logic                      item_valid;
  logic                      item_stall;
  logic [7:0]                rx_byte;
  logic [15:0]               tick;
  logic                      result_valid;
  logic                      result_stall;
  logic                      data_valid;
  logic [7:0]                data_byte;
  logic [sfd_pkg::OFF_W-1:0] data_offset;
  logic                      byte_dropped;
  logic                      frame_done;
  logic [sfd_pkg::CNT_W-1:0] frame_length;
  logic                      send_client_reply;

  slip_scoreboard sb;
  int             cycles;
  int             sent;
  logic           quiet;
  logic           gaps_on;
  logic [15:0]    tick_now;
  logic [15:0]    cur_thr;

  slip_frame_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .rx_byte(rx_byte),
    .tick(tick),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .data_valid(data_valid),
    .data_byte(data_byte),
    .data_offset(data_offset),
    .byte_dropped(byte_dropped),
    .frame_done(frame_done),
    .frame_length(frame_length),
    .send_client_reply(send_client_reply)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    sfd_pkg::sfd_result_t got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_gap_threshold(cfg_data);
      if (item_valid && !item_stall) sb.decode_byte(rx_byte, tick);
      if (result_valid && !result_stall) begin
        got.data_valid        = data_valid;
        got.data_byte         = data_byte;
        got.data_offset       = data_offset;
        got.byte_dropped      = byte_dropped;
        got.frame_done        = frame_done;
        got.frame_length      = frame_length;
        got.send_client_reply = send_client_reply;
        sb.check_result(got);
      end
    end
  end

  // result side back-pressure
  initial begin
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!quiet) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            result_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            result_stall <= 1'b0;
          end
          2: repeat ($urandom_range(20, 60)) @(posedge clk);
          default: ;
        endcase
      end
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == sfd_pkg::END_CODE || v == sfd_pkg::ESC_CODE);
    return v;
  endfunction

  function automatic logic [7:0] client_char(int i);
    return sfd_pkg::CLIENT_WORD[47 - 8 * i -: 8];
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [15:0] t);
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    rx_byte    <= b;
    tick       <= t;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  task automatic send_next(input logic [7:0] b);
    tick_now = tick_now + 16'($urandom_range(0, 3));
    send_item(b, tick_now);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    cur_thr = v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_escape_pair();
    logic [7:0] v;
    case ($urandom_range(0, 4))
      0: v = sfd_pkg::ESC_END_CODE;
      1: v = sfd_pkg::ESC_ESC_CODE;
      2: v = sfd_pkg::END_CODE;
      3: v = sfd_pkg::ESC_CODE;
      default: v = 8'($urandom_range(0, 255));
    endcase
    send_next(sfd_pkg::ESC_CODE);
    send_next(v);
  endtask

  task automatic directed();
    send_item(sfd_pkg::END_CODE, 16'h0000);
    send_item(8'h00, 16'h0001);
    send_item(8'hFF, 16'h0002);
    send_item(sfd_pkg::ESC_CODE, 16'h0003);
    send_item(sfd_pkg::ESC_END_CODE, 16'h0004);
    send_item(sfd_pkg::ESC_CODE, 16'h0005);
    send_item(sfd_pkg::ESC_ESC_CODE, 16'h0006);
    send_item(sfd_pkg::ESC_CODE, 16'h0007);
    send_item(sfd_pkg::END_CODE, 16'h0008);
    send_item(sfd_pkg::ESC_CODE, 16'h0009);
    send_item(sfd_pkg::ESC_CODE, 16'h000A);
    send_item(sfd_pkg::ESC_CODE, 16'h000B);
    send_item(8'h41, 16'h000C);
    send_item(sfd_pkg::END_CODE, 16'h000D);
    for (int i = 0; i < 6; i++) send_item(client_char(i), 16'hFFFF);
    send_item(sfd_pkg::END_CODE, 16'hFFFF);
    tick_now = 16'hFFFF;
  endtask

  // overruns the frame limit, including escaped bytes past the end
  task automatic long_frame();
    for (int i = 0; i < 1028; i++) send_next(plain_byte());
    send_next(sfd_pkg::ESC_CODE);
    send_next(sfd_pkg::ESC_END_CODE);
    send_next(sfd_pkg::ESC_CODE);
    send_next(sfd_pkg::ESC_CODE);
    send_next(sfd_pkg::END_CODE);
  endtask

  task automatic random_items(input int n);
    int start;
    int len;
    int bad;
    start = sent;
    while (sent - start < n) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) send_escape_pair();
            else send_next(plain_byte());
          end
          send_next(sfd_pkg::END_CODE);
        end
        5, 6: begin
          send_next(sfd_pkg::END_CODE);
          tick_now = tick_now + cur_thr + 16'd1 + 16'($urandom_range(0, 50));
          bad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : -1;
          for (int i = 0; i < 6; i++) begin
            if (i == bad) send_item(8'($urandom_range(0, 255)), tick_now);
            else send_item(client_char(i), tick_now);
          end
          if ($urandom_range(0, 1) == 0) send_next(sfd_pkg::END_CODE);
        end
        7: begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
        8: begin
          case ($urandom_range(0, 2))
            0: begin
              send_next(sfd_pkg::ESC_CODE);
              send_next(sfd_pkg::END_CODE);
            end
            1: begin
              send_next(sfd_pkg::END_CODE);
              send_next(sfd_pkg::END_CODE);
            end
            default: begin
              for (int i = 0; i < 5; i++) send_next(client_char(i));
              send_next(plain_byte());
            end
          endcase
        end
        default: begin
          tick_now = 16'($urandom_range(0, 65535));
          send_next(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    item_valid   = 1'b0;
    rx_byte      = '0;
    tick         = '0;
    result_stall = 1'b0;
    cycles       = 0;
    sent         = 0;
    quiet        = 1'b0;
    gaps_on      = 1'b1;
    tick_now     = '0;
    cur_thr      = sfd_pkg::GAP_THRESHOLD_RESET;
    sb           = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    long_frame();
    drain();
    write_threshold(16'd0);
    random_items(30);
    drain();
    write_threshold(16'hFFFF);
    random_items(20);
    drain();
    write_threshold(16'($urandom_range(1, 65534)));
    random_items(30);
    drain();
    write_threshold(16'd8);
    random_items(30);
    drain();
    quiet = 1'b1;
    write_threshold(16'd30);
    random_items(40);
    drain();

    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
